>>> rtl/core/stxdf_pkg.sv
// Shared constants, codes and controller/datapath interface types of the STX frame receiver.
package stxdf_pkg;

  localparam int BUF_DEPTH_DEF = 128;
  localparam int PAY_DEPTH     = 128;
  localparam int PAY_AW        = 7;

  localparam logic [7:0] FRAME_STX      = 8'd2;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
  localparam logic [6:0] MAX_PAYLOAD_RST = 7'd124;

  localparam int POS_SIZE    = 1;
  localparam int POS_TYPE    = 2;
  localparam int POS_PAYLOAD = 3;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic CFG_IDX_MAX_PAYLOAD = 1'b0;

  typedef enum logic [2:0] {
    OFF_HOLD,
    OFF_INC,
    OFF_ZERO,
    OFF_ONE,
    OFF_THREE
  } off_op_t;

  typedef enum logic [1:0] {
    DROP_NONE,
    DROP_OFF,
    DROP_SIZE,
    DROP_ALL
  } drop_op_t;

  typedef struct packed {
    logic       load;
    logic       push_wr;
    off_op_t    off_op;
    drop_op_t   drop_op;
    logic       bad_set;
    logic       size_ld;
    logic       sum_clr;
    logic       sum_acc;
    logic       copy_wr;
    logic       last_ld;
    logic       out_ld;
    logic [1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic item_rd;
    logic head_bad;
    logic off_ge_fill;
    logic byte_stx;
    logic fill_lt2;
    logic size_bad;
    logic fill_lt_size;
    logic sum_last;
    logic sum_zero;
    logic plen_gt_max;
    logic plen_zero;
    logic copy_last;
    logic idx_hit;
  } dp_stat_t;

endpackage

>>> rtl/core/stx_length_checksum_deframer.sv
// Top level of the STX/size/type/payload/checksum frame receiver. Each input item either
// pushes one received byte (tuser 0) or reads one byte of the last accepted payload
// (tuser 1), and yields exactly one result item. The block works on one item at a time; the
// receive store sits in a single-port-read circular memory walked by one offset counter, one
// byte per cycle. A read checks its index against the last payload length and completes. A
// push writes the byte, sets up the scan offset and runs the resync scan (up to the next STX,
// at most the fill count plus one bytes) and, once a frame is complete, the checksum pass
// over the frame bytes, the frame check and the copy of the payload bytes. The scanned bytes
// and the frame bytes together never exceed the fill count. The result register takes the
// next result only after the previous one has been taken.
module stx_length_checksum_deframer #(
  parameter int BUF_DEPTH = stxdf_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [7:0] rx_byte, [14:8] read_index, [15] zero
  input  logic [0:0]  in_tuser,     // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [7:0] frame_type, [14:8] payload_len, [22:15] read_data
  output logic [1:0]  out_tuser,    // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  stxdf_pkg::dp_cmd_t  cmd;
  stxdf_pkg::dp_stat_t stat;

  logic [6:0] max_payload_r;
  logic       cfg_wr;
  logic [1:0] out_status;
  logic [7:0] out_frame_type;
  logic [6:0] out_payload_len;
  logic [7:0] out_read_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == stxdf_pkg::CFG_IDX_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= stxdf_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      max_payload_r <= cfg_pwdata[6:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == stxdf_pkg::CFG_IDX_MAX_PAYLOAD) ?
                      {25'd0, max_payload_r} : 32'd0;

  stxdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .item_cmd   (in_tuser[0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  stxdf_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_payload     (max_payload_r),
    .item_cmd        (in_tuser[0]),
    .item_rx_byte    (in_tdata[7:0]),
    .item_read_index (in_tdata[14:8]),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_frame_type  (out_frame_type),
    .out_payload_len (out_payload_len),
    .out_read_data   (out_read_data)
  );

  assign out_tdata = {1'b0, out_read_data, out_payload_len, out_frame_type};
  assign out_tuser = out_status;

endmodule

>>> rtl/core/stxdf_dp.sv
// Datapath: circular receive store, payload store, offset walker, checksum and result register.
module stxdf_dp #(
  parameter int BUF_DEPTH = stxdf_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          max_payload,
  input  logic                item_cmd,
  input  logic [7:0]          item_rx_byte,
  input  logic [6:0]          item_read_index,
  input  stxdf_pkg::dp_cmd_t  cmd,
  output stxdf_pkg::dp_stat_t stat,
  output logic [1:0]          out_status,
  output logic [7:0]          out_frame_type,
  output logic [6:0]          out_payload_len,
  output logic [7:0]          out_read_data
);

  localparam int HW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int EW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(BUF_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);
  localparam logic [EW-1:0] DEPTH_E = EW'(BUF_DEPTH);

  logic [7:0] rx_mem [BUF_DEPTH];
  logic [7:0] pay_mem [stxdf_pkg::PAY_DEPTH];

  logic [7:0]     rdata_r;
  logic [7:0]     pdata_r;
  logic [HW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           head_bad_r, head_bad_nxt;
  logic [CW-1:0]  off_r, off_nxt;
  logic [7:0]     size_r;
  logic [7:0]     sum_r;
  logic [7:0]     type_r;
  logic           item_cmd_r;
  logic [7:0]     item_byte_r;
  logic [6:0]     item_idx_r;
  logic [7:0]     last_type_r;
  logic [6:0]     last_len_r;
  logic [1:0]     out_status_r;
  logic [7:0]     out_type_r;
  logic [6:0]     out_len_r;
  logic [7:0]     out_data_r;

  logic [CW-1:0]  drop_n;
  logic [HW-1:0]  waddr;
  logic [HW-1:0]  raddr;
  logic           wr_en;
  logic [7:0]     plen;
  logic [stxdf_pkg::PAY_AW-1:0] pidx;

  function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(ofs);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[HW-1:0];
  endfunction

  assign plen  = size_r - stxdf_pkg::FRAME_OVERHEAD;
  assign wr_en = cmd.push_wr && (fill_r < DEPTH_C);
  assign waddr = wrap_add(head_r, fill_r);
  assign pidx  = stxdf_pkg::PAY_AW'(EW'(off_r) - EW'(stxdf_pkg::POS_PAYLOAD));

  always_comb begin
    unique case (cmd.off_op)
      stxdf_pkg::OFF_HOLD:  off_nxt = off_r;
      stxdf_pkg::OFF_INC:   off_nxt = off_r + CW'(1);
      stxdf_pkg::OFF_ZERO:  off_nxt = '0;
      stxdf_pkg::OFF_ONE:   off_nxt = CW'(stxdf_pkg::POS_SIZE);
      stxdf_pkg::OFF_THREE: off_nxt = CW'(stxdf_pkg::POS_PAYLOAD);
      default:              off_nxt = off_r;
    endcase
  end

  always_comb begin
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    head_bad_nxt = head_bad_r;
    drop_n       = (cmd.drop_op == stxdf_pkg::DROP_SIZE) ? CW'(size_r) : off_r;
    if (wr_en) begin
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.bad_set) begin
      head_bad_nxt = 1'b1;
    end
    unique case (cmd.drop_op)
      stxdf_pkg::DROP_NONE: ;
      stxdf_pkg::DROP_OFF, stxdf_pkg::DROP_SIZE: begin
        head_nxt     = wrap_add(head_r, drop_n);
        fill_nxt     = fill_r - drop_n;
        head_bad_nxt = 1'b0;
      end
      stxdf_pkg::DROP_ALL: begin
        fill_nxt     = '0;
        head_bad_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  assign raddr = wrap_add(head_nxt, off_nxt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rx_mem[waddr] <= item_byte_r;
    end
    rdata_r <= rx_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_wr) begin
      pay_mem[pidx] <= rdata_r;
    end
    if (cmd.load) begin
      pdata_r <= pay_mem[item_read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      head_bad_r  <= 1'b0;
      last_type_r <= '0;
      last_len_r  <= '0;
    end else begin
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      head_bad_r <= head_bad_nxt;
      if (cmd.last_ld) begin
        last_type_r <= type_r;
        last_len_r  <= plen[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    if (cmd.load) begin
      item_cmd_r  <= item_cmd;
      item_byte_r <= item_rx_byte;
      item_idx_r  <= item_read_index;
    end
    if (cmd.size_ld) begin
      size_r <= rdata_r;
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_acc) begin
      sum_r <= sum_r + rdata_r;
    end
    if (cmd.sum_acc && (off_r == CW'(stxdf_pkg::POS_TYPE))) begin
      type_r <= rdata_r;
    end
    if (cmd.out_ld) begin
      out_status_r <= cmd.out_status;
      out_type_r   <= last_type_r;
      out_len_r    <= last_len_r;
      out_data_r   <= (cmd.out_status == stxdf_pkg::ST_READ) ? pdata_r : 8'd0;
    end
  end

  always_comb begin
    stat.item_rd      = (item_cmd_r == stxdf_pkg::CMD_READ);
    stat.head_bad     = head_bad_r;
    stat.off_ge_fill  = (off_r >= fill_r);
    stat.byte_stx     = (rdata_r == stxdf_pkg::FRAME_STX);
    stat.fill_lt2     = (fill_r < CW'(2));
    stat.size_bad     = (rdata_r < stxdf_pkg::FRAME_OVERHEAD) || (EW'(rdata_r) > DEPTH_E);
    stat.fill_lt_size = (EW'(fill_r) < EW'(rdata_r));
    stat.sum_last     = ((EW'(off_r) + EW'(1)) == EW'(size_r));
    stat.sum_zero     = (sum_r == 8'd0);
    stat.plen_gt_max  = (plen > {1'b0, max_payload});
    stat.plen_zero    = (plen == 8'd0);
    stat.copy_last    = ((EW'(off_r) + EW'(2)) == EW'(size_r));
    stat.idx_hit      = (item_idx_r < last_len_r);
  end

  assign out_status      = out_status_r;
  assign out_frame_type  = out_type_r;
  assign out_payload_len = out_len_r;
  assign out_read_data   = out_data_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("receive store fill count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(head_r) < DEPTH_S)
    else $error("receive store head pointer out of range");

  a_drop_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drop_op == stxdf_pkg::DROP_SIZE) |-> (EW'(size_r) <= EW'(fill_r)))
    else $error("frame drop larger than stored bytes");
`endif

endmodule

>>> rtl/core/stxdf_ctrl.sv
// Controller: sequences push, resync scan, header check, checksum pass, payload copy and reads.
module stxdf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                item_cmd,
  input  logic                out_tready,
  output logic                out_tvalid,
  input  stxdf_pkg::dp_stat_t stat,
  output stxdf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_PREP,
    S_SCAN,
    S_SIZE,
    S_SUM,
    S_CHK,
    S_COPY,
    S_RDEC,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    in_tready     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (item_cmd == stxdf_pkg::CMD_PUSH) ? S_PUSH : S_RDEC;
        end
      end
      S_PUSH: begin
        cmd.push_wr = 1'b1;
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        cmd.off_op = stat.head_bad ? stxdf_pkg::OFF_ONE : stxdf_pkg::OFF_ZERO;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (stat.off_ge_fill) begin
          cmd.drop_op = stxdf_pkg::DROP_ALL;
          cmd.off_op  = stxdf_pkg::OFF_ONE;
          state_nxt   = S_SIZE;
        end else if (stat.byte_stx) begin
          cmd.drop_op = stxdf_pkg::DROP_OFF;
          cmd.off_op  = stxdf_pkg::OFF_ONE;
          state_nxt   = S_SIZE;
        end else begin
          cmd.off_op = stxdf_pkg::OFF_INC;
        end
      end
      S_SIZE: begin
        status_nxt = stxdf_pkg::ST_NONE;
        if (stat.fill_lt2) begin
          state_nxt = S_DONE;
        end else if (stat.size_bad) begin
          cmd.bad_set = 1'b1;
          state_nxt   = S_DONE;
        end else if (stat.fill_lt_size) begin
          state_nxt = S_DONE;
        end else begin
          cmd.size_ld = 1'b1;
          cmd.sum_clr = 1'b1;
          cmd.off_op  = stxdf_pkg::OFF_ZERO;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_acc = 1'b1;
        if (stat.sum_last) begin
          state_nxt = S_CHK;
        end else begin
          cmd.off_op = stxdf_pkg::OFF_INC;
        end
      end
      S_CHK: begin
        if (!stat.sum_zero) begin
          cmd.bad_set = 1'b1;
          status_nxt  = stxdf_pkg::ST_NONE;
          state_nxt   = S_DONE;
        end else if (stat.plen_gt_max) begin
          cmd.drop_op = stxdf_pkg::DROP_SIZE;
          status_nxt  = stxdf_pkg::ST_TOO_BIG;
          state_nxt   = S_DONE;
        end else if (stat.plen_zero) begin
          cmd.last_ld = 1'b1;
          cmd.drop_op = stxdf_pkg::DROP_SIZE;
          status_nxt  = stxdf_pkg::ST_ACCEPT;
          state_nxt   = S_DONE;
        end else begin
          cmd.last_ld = 1'b1;
          cmd.off_op  = stxdf_pkg::OFF_THREE;
          state_nxt   = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_wr = 1'b1;
        if (stat.copy_last) begin
          cmd.drop_op = stxdf_pkg::DROP_SIZE;
          status_nxt  = stxdf_pkg::ST_ACCEPT;
          state_nxt   = S_DONE;
        end else begin
          cmd.off_op = stxdf_pkg::OFF_INC;
        end
      end
      S_RDEC: begin
        status_nxt = stat.idx_hit ? stxdf_pkg::ST_READ : stxdf_pkg::ST_NONE;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_ld     = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.out_status = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= stxdf_pkg::ST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in work");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the completion state");

  a_read_status_only_for_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == stxdf_pkg::ST_READ) |-> stat.item_rd)
    else $error("read status on a push item");
`endif

endmodule
